// File: src/apt_pkg.sv
package apt_pkg;

    localparam int MAX_MEMBERS = 16;
    localparam int ID_BITS     = 32;
    localparam int PERM_BITS   = 16;
    localparam int DATA_W      = 32;
    localparam int PADDR_W     = 3;
    localparam int IDX_W       = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int CNT_W       = $clog2(MAX_MEMBERS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // operation codes
    localparam logic [1:0] OP_GRANT  = 2'd0;
    localparam logic [1:0] OP_REVOKE = 2'd1;
    localparam logic [1:0] OP_CHECK  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // register index of the owner id
    localparam logic [PADDR_W-1:0] ADDR_OWNER = '0;

    typedef struct packed {
        logic [1:0]           op;
        logic [ID_BITS-1:0]   client_id;
        logic [PERM_BITS-1:0] perm_mask;
    } apt_req_t;

    typedef struct packed {
        logic ok;
        logic table_full;
    } apt_rsp_t;

    // class of a request as decided in the front part
    typedef enum logic [1:0] {
        CLS_IGNORE,
        CLS_OWNER,
        CLS_OTHERS,
        CLS_MEMBER
    } apt_class_t;

    typedef struct packed {
        apt_class_t           cls;
        logic [1:0]           op;
        logic [ID_BITS-1:0]   client_id;
        logic [PERM_BITS-1:0] perm_mask;
    } apt_cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_SEARCH
    } apt_back_state_t;

endpackage

// File: src/apt_front.sv
module apt_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  apt_pkg::apt_req_t      req,
    input  logic [apt_pkg::ID_BITS-1:0] owner_id,
    input  logic                   q_full,
    output logic                   busy,
    output logic                   push,
    output apt_pkg::apt_cmd_t      cmd
);

    logic              valid_reg;
    logic              valid_next;
    apt_pkg::apt_cmd_t cmd_reg;
    apt_pkg::apt_cmd_t cmd_next;
    logic              accept;

    assign busy   = valid_reg;
    assign accept = start && !valid_reg;
    assign push   = valid_reg && !q_full;
    assign cmd    = cmd_reg;

    // classify the incoming word
    always_comb
    begin
        cmd_next           = cmd_reg;
        cmd_next.op        = req.op;
        cmd_next.client_id = req.client_id;
        cmd_next.perm_mask = req.perm_mask;
        priority if (req.op == apt_pkg::OP_UNUSED)
        begin
            cmd_next.cls = apt_pkg::CLS_IGNORE;
        end
        else if (req.client_id == owner_id)
        begin
            cmd_next.cls = apt_pkg::CLS_OWNER;
        end
        else if (req.client_id == '0)
        begin
            cmd_next.cls = apt_pkg::CLS_OTHERS;
        end
        else
        begin
            cmd_next.cls = apt_pkg::CLS_MEMBER;
        end
    end

    // hold the word until the queue takes it
    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// File: src/apt_queue.sv
module apt_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  apt_pkg::apt_cmd_t push_cmd,
    input  logic              pop,
    output apt_pkg::apt_cmd_t head,
    output logic              full,
    output logic              empty
);

    apt_pkg::apt_cmd_t                slot_reg [apt_pkg::QUEUE_DEPTH];
    logic [apt_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [apt_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [apt_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [apt_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [apt_pkg::QCNT_W-1:0]       count_reg;
    logic [apt_pkg::QCNT_W-1:0]       count_next;

    assign full  = (count_reg == apt_pkg::QCNT_W'(apt_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == apt_pkg::QPTR_W'(apt_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == apt_pkg::QPTR_W'(apt_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // the front never offers a word to a full queue, and the back never drains an empty one
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("queue read while empty");

endmodule

// File: src/apt_back.sv
module apt_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  apt_pkg::apt_cmd_t head,
    output logic              pop,
    output logic              done,
    output apt_pkg::apt_rsp_t rsp
);

    apt_pkg::apt_back_state_t        state_reg;
    apt_pkg::apt_back_state_t        state_next;
    apt_pkg::apt_cmd_t               cmd_reg;
    apt_pkg::apt_cmd_t               cmd_next;
    logic [apt_pkg::PERM_BITS-1:0]   others_reg;
    logic [apt_pkg::PERM_BITS-1:0]   others_next;
    logic [apt_pkg::CNT_W-1:0]       count_reg;
    logic [apt_pkg::CNT_W-1:0]       count_next;
    logic [apt_pkg::CNT_W-1:0]       idx_reg;
    logic [apt_pkg::CNT_W-1:0]       idx_next;
    logic                            rd_valid_reg;
    logic                            rd_valid_next;
    logic                            done_reg;
    logic                            done_next;
    apt_pkg::apt_rsp_t               rsp_reg;
    apt_pkg::apt_rsp_t               rsp_next;

    // member table
    logic [apt_pkg::ID_BITS-1:0]     client_mem [apt_pkg::MAX_MEMBERS];
    logic [apt_pkg::PERM_BITS-1:0]   mask_mem   [apt_pkg::MAX_MEMBERS];
    logic [apt_pkg::ID_BITS-1:0]     rd_client_reg;
    logic [apt_pkg::PERM_BITS-1:0]   rd_mask_reg;
    logic [apt_pkg::IDX_W-1:0]       cmp_idx_reg;
    logic                            rd_en;
    logic                            mem_we;
    logic [apt_pkg::IDX_W-1:0]       mem_waddr;
    logic [apt_pkg::PERM_BITS-1:0]   mem_wmask;

    logic                            hit;
    logic                            more;
    logic                            room;

    assign done = done_reg;
    assign rsp  = rsp_reg;

    assign hit  = rd_valid_reg && (rd_client_reg == cmd_reg.client_id);
    assign more = (idx_reg < count_reg);
    assign room = (count_reg < apt_pkg::CNT_W'(apt_pkg::MAX_MEMBERS));

    // take commands, walk the table one entry a cycle
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        others_next   = others_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        rd_valid_next = 1'b0;
        done_next     = 1'b0;
        rsp_next      = '0;
        pop           = 1'b0;
        rd_en         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = cmp_idx_reg;
        mem_wmask     = rd_mask_reg;
        unique case (state_reg)
            apt_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    unique case (head.cls)
                        apt_pkg::CLS_IGNORE:
                        begin
                            done_next = 1'b1;
                        end
                        apt_pkg::CLS_OWNER:
                        begin
                            done_next   = 1'b1;
                            rsp_next.ok = (head.op != apt_pkg::OP_REVOKE);
                        end
                        apt_pkg::CLS_OTHERS:
                        begin
                            done_next = 1'b1;
                            unique case (head.op)
                                apt_pkg::OP_GRANT:
                                begin
                                    others_next = others_reg | head.perm_mask;
                                    rsp_next.ok = 1'b1;
                                end
                                apt_pkg::OP_REVOKE:
                                begin
                                    others_next = others_reg & ~head.perm_mask;
                                    rsp_next.ok = 1'b1;
                                end
                                apt_pkg::OP_CHECK:
                                begin
                                    rsp_next.ok = |(others_reg & head.perm_mask);
                                end
                                default:
                                begin
                                    rsp_next.ok = 1'b0;
                                end
                            endcase
                        end
                        apt_pkg::CLS_MEMBER:
                        begin
                            idx_next   = '0;
                            state_next = apt_pkg::BK_SEARCH;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            apt_pkg::BK_SEARCH:
            begin
                priority if (hit)
                begin
                    // answer from the matching entry, updating it on grant and revoke
                    done_next  = 1'b1;
                    state_next = apt_pkg::BK_IDLE;
                    unique case (cmd_reg.op)
                        apt_pkg::OP_GRANT:
                        begin
                            mem_we      = 1'b1;
                            mem_wmask   = rd_mask_reg | cmd_reg.perm_mask;
                            rsp_next.ok = 1'b1;
                        end
                        apt_pkg::OP_REVOKE:
                        begin
                            mem_we      = 1'b1;
                            mem_wmask   = rd_mask_reg & ~cmd_reg.perm_mask;
                            rsp_next.ok = 1'b1;
                        end
                        apt_pkg::OP_CHECK:
                        begin
                            rsp_next.ok = |(rd_mask_reg & cmd_reg.perm_mask);
                        end
                        default:
                        begin
                            rsp_next.ok = 1'b0;
                        end
                    endcase
                end
                else if (more)
                begin
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    idx_next      = idx_reg + 1'b1;
                end
                else
                begin
                    // no entry for this client
                    done_next  = 1'b1;
                    state_next = apt_pkg::BK_IDLE;
                    unique case (cmd_reg.op)
                        apt_pkg::OP_GRANT:
                        begin
                            if (room)
                            begin
                                mem_we      = 1'b1;
                                mem_waddr   = count_reg[apt_pkg::IDX_W-1:0];
                                mem_wmask   = cmd_reg.perm_mask;
                                count_next  = count_reg + 1'b1;
                                rsp_next.ok = 1'b1;
                            end
                            else
                            begin
                                rsp_next.table_full = 1'b1;
                            end
                        end
                        apt_pkg::OP_REVOKE:
                        begin
                            rsp_next.ok = 1'b1;
                        end
                        default:
                        begin
                            rsp_next.ok = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = apt_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= apt_pkg::BK_IDLE;
            others_reg   <= '0;
            count_reg    <= '0;
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            others_reg   <= others_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            rd_valid_reg <= rd_valid_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        rsp_reg <= rsp_next;
    end

    // table write port and registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            client_mem[mem_waddr] <= cmd_reg.client_id;
            mask_mem[mem_waddr]   <= mem_wmask;
        end
        if (rd_en)
        begin
            rd_client_reg <= client_mem[idx_reg[apt_pkg::IDX_W-1:0]];
            rd_mask_reg   <= mask_mem[idx_reg[apt_pkg::IDX_W-1:0]];
            cmp_idx_reg   <= idx_reg[apt_pkg::IDX_W-1:0];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= apt_pkg::CNT_W'(apt_pkg::MAX_MEMBERS))
        else $error("member count beyond table size");

    a_full_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && rsp_reg.table_full |-> !rsp_reg.ok)
        else $error("full table reported with success");

    a_search_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == apt_pkg::BK_SEARCH) |-> !pop)
        else $error("queue drained during a table search");

endmodule

// File: src/access_permission_table_unit.sv
// Access permission table for one object.
// Request channel: drive req (op, client_id, perm_mask) with start; the word
// is taken at a rising edge where start is high and busy is low. busy rises
// after each accepted word and stays high until the word moves into the queue.
// Result channel: done is high for exactly one cycle with rsp (ok,
// table_full); the receiver cannot stall, so every result must be taken then.
// Flow: an owner, client zero or unused-op word passes the front register, a
// queue slot and the done register. A member word searches the table one entry
// per cycle through the registered read port and ends at a hit or after the
// last of count entries, count being the number of members (at most 16). Words
// queue up behind a search, up to two deep, and the front takes a new word
// once the previous one has moved into the queue, until the queue fills.
// Configuration: the owner id lies at APB byte address 0; pready is always
// high. The user must make writes only while no word is in flight; the block
// itself does not enforce this.
// Reset: clears the owner id, the shared mask, the member count and the
// queue; the member table needs no clearing since only counted entries are read.
module access_permission_table_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  apt_pkg::apt_req_t             req,
    output logic                          busy,
    output logic                          done,
    output apt_pkg::apt_rsp_t             rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [apt_pkg::PADDR_W-1:0]   paddr,
    input  logic [apt_pkg::DATA_W-1:0]    pwdata,
    output logic [apt_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    logic [apt_pkg::ID_BITS-1:0] owner_reg;
    logic [apt_pkg::ID_BITS-1:0] owner_next;
    logic                        owner_sel;
    logic                        cfg_write;

    logic                        q_push;
    logic                        q_pop;
    logic                        q_full;
    logic                        q_empty;
    apt_pkg::apt_cmd_t           front_cmd;
    apt_pkg::apt_cmd_t           q_head;

    assign pready    = 1'b1;
    assign owner_sel = (paddr[apt_pkg::PADDR_W-1:2] == apt_pkg::ADDR_OWNER[apt_pkg::PADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // register file
    always_comb
    begin
        owner_next = owner_reg;
        if (cfg_write && owner_sel)
        begin
            owner_next = pwdata[apt_pkg::ID_BITS-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (owner_sel)
        begin
            prdata = apt_pkg::DATA_W'(owner_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_reg <= '0;
        end
        else
        begin
            owner_reg <= owner_next;
        end
    end

    apt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .owner_id (owner_reg),
        .q_full   (q_full),
        .busy     (busy),
        .push     (q_push),
        .cmd      (front_cmd)
    );

    apt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    apt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .head    (q_head),
        .pop     (q_pop),
        .done    (done),
        .rsp     (rsp)
    );

endmodule

// File: tb/sv/apt_checker.sv
module apt_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  apt_pkg::apt_req_t            req,
    input  logic                         done,
    input  apt_pkg::apt_rsp_t            rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [apt_pkg::PADDR_W-1:0]  paddr,
    input  logic [apt_pkg::DATA_W-1:0]   pwdata,
    output int                           mismatches,
    output int                           outstanding,
    output int                           words_taken,
    output int                           full_rejects
);

    // shadow copy of the table and the owner register
    logic [apt_pkg::ID_BITS-1:0]   owner_reg;
    logic [apt_pkg::PERM_BITS-1:0] shared_mask;
    int                            member_total;
    logic [apt_pkg::ID_BITS-1:0]   member_id   [apt_pkg::MAX_MEMBERS];
    logic [apt_pkg::PERM_BITS-1:0] member_bits [apt_pkg::MAX_MEMBERS];

    apt_pkg::apt_rsp_t expected_rsp_q[$];

    // apply one request to the shadow table and return its answer
    function automatic apt_pkg::apt_rsp_t predict_access(input apt_pkg::apt_req_t r);
        apt_pkg::apt_rsp_t res;
        int                slot;
        res  = '0;
        slot = -1;
        if (r.op == apt_pkg::OP_UNUSED)
        begin
            res = '0;
        end
        else if (r.client_id == owner_reg)
        begin
            res.ok = (r.op != apt_pkg::OP_REVOKE);
        end
        else if (r.client_id == '0)
        begin
            case (r.op)
                apt_pkg::OP_GRANT:
                begin
                    shared_mask = shared_mask | r.perm_mask;
                    res.ok = 1'b1;
                end
                apt_pkg::OP_REVOKE:
                begin
                    shared_mask = shared_mask & ~r.perm_mask;
                    res.ok = 1'b1;
                end
                default: res.ok = |(shared_mask & r.perm_mask);
            endcase
        end
        else
        begin
            for (int i = 0; i < member_total; i++)
                if (slot < 0 && member_id[i] == r.client_id)
                    slot = i;
            if (slot >= 0)
            begin
                case (r.op)
                    apt_pkg::OP_GRANT:
                    begin
                        member_bits[slot] = member_bits[slot] | r.perm_mask;
                        res.ok = 1'b1;
                    end
                    apt_pkg::OP_REVOKE:
                    begin
                        member_bits[slot] = member_bits[slot] & ~r.perm_mask;
                        res.ok = 1'b1;
                    end
                    default: res.ok = |(member_bits[slot] & r.perm_mask);
                endcase
            end
            else if (r.op == apt_pkg::OP_GRANT)
            begin
                if (member_total < apt_pkg::MAX_MEMBERS)
                begin
                    member_id[member_total]   = r.client_id;
                    member_bits[member_total] = r.perm_mask;
                    member_total++;
                    res.ok = 1'b1;
                end
                else
                begin
                    res.table_full = 1'b1;
                end
            end
            else
            begin
                // revoke from a stranger succeeds without an entry; check fails
                res.ok = (r.op == apt_pkg::OP_REVOKE);
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        apt_pkg::apt_rsp_t want;
        if (!rst_n)
        begin
            owner_reg    = '0;
            shared_mask  = '0;
            member_total = 0;
            mismatches   = 0;
            words_taken  = 0;
            full_rejects = 0;
            expected_rsp_q.delete();
            outstanding <= 0;
        end
        else
        begin
            // compare a finished word against the oldest prediction
            if (done)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $error("result word with no request pending");
                    mismatches++;
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.ok !== want.ok)
                    begin
                        $error("ok: expected %0b, got %0b", want.ok, rsp.ok);
                        mismatches++;
                    end
                    if (rsp.table_full !== want.table_full)
                    begin
                        $error("table_full: expected %0b, got %0b",
                               want.table_full, rsp.table_full);
                        mismatches++;
                    end
                end
            end
            // track owner register writes
            if (psel && penable && pwrite && pready && paddr == apt_pkg::ADDR_OWNER)
                owner_reg = pwdata[apt_pkg::ID_BITS-1:0];
            // predict each accepted request word
            if (start && !busy)
            begin
                want = predict_access(req);
                if (want.table_full)
                    full_rejects++;
                words_taken++;
                expected_rsp_q.push_back(want);
            end
            outstanding <= expected_rsp_q.size();
        end
    end

endmodule

// File: tb/sv/tb.sv
module tb;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 24;
    localparam int PHASE_WORDS = 280;

    logic                         clk;
    logic                         rst_n   = 1'b0;
    logic                         start   = 1'b0;
    apt_pkg::apt_req_t            req     = '0;
    logic                         busy;
    logic                         done;
    apt_pkg::apt_rsp_t            rsp;
    logic                         psel    = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite  = 1'b0;
    logic [apt_pkg::PADDR_W-1:0]  paddr   = '0;
    logic [apt_pkg::DATA_W-1:0]   pwdata  = '0;
    logic [apt_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    int mismatches;
    int outstanding;
    int words_taken;
    int full_rejects;
    int stall_cycles = 0;

    logic [apt_pkg::ID_BITS-1:0] owner_now;
    logic [apt_pkg::ID_BITS-1:0] member_pool [apt_pkg::MAX_MEMBERS];

    access_permission_table_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req     (req),
        .busy    (busy),
        .done    (done),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    apt_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .done         (done),
        .rsp          (rsp),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .words_taken  (words_taken),
        .full_rejects (full_rejects)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable && pready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // hold the word until the block takes it
    task automatic issue(input logic [1:0] op, input logic [apt_pkg::ID_BITS-1:0] id,
                         input logic [apt_pkg::PERM_BITS-1:0] mask);
        apt_pkg::apt_req_t w;
        w.op        = op;
        w.client_id = id;
        w.perm_mask = mask;
        start <= 1'b1;
        req   <= w;
        do @(posedge clk); while (busy);
    endtask

    task automatic pause(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // drop start and wait for every pending result
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_owner(input logic [apt_pkg::ID_BITS-1:0] v);
        drain();
        repeat (SETTLE) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= apt_pkg::ADDR_OWNER;
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        owner_now = v;
    endtask

    function automatic logic [apt_pkg::PERM_BITS-1:0] pick_mask();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10)
            return '1;
        else if (sel < 15)
            return '0;
        else if (sel < 35)
            return apt_pkg::PERM_BITS'(1) << $urandom_range(apt_pkg::PERM_BITS - 1);
        return apt_pkg::PERM_BITS'($urandom);
    endfunction

    function automatic logic [apt_pkg::ID_BITS-1:0] pick_client();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50)
            return member_pool[$urandom_range(apt_pkg::MAX_MEMBERS - 1)];
        else if (sel < 65)
            return '0;
        else if (sel < 75)
            return owner_now;
        else if (sel < 90)
            return apt_pkg::ID_BITS'($urandom);
        // near miss: a member id with one bit flipped
        return member_pool[$urandom_range(apt_pkg::MAX_MEMBERS - 1)]
               ^ (apt_pkg::ID_BITS'(1) << $urandom_range(apt_pkg::ID_BITS - 1));
    endfunction

    // random traffic with a given share of idle cycles on the request side
    task automatic run_phase(input int words, input int idle_pct);
        int         sent;
        logic [1:0] op;
        sent = 0;
        while (sent < words)
        begin
            if ($urandom_range(99) < 3)
                op = apt_pkg::OP_UNUSED;
            else
            begin
                case ($urandom_range(2))
                    0:       op = apt_pkg::OP_GRANT;
                    1:       op = apt_pkg::OP_REVOKE;
                    default: op = apt_pkg::OP_CHECK;
                endcase
            end
            issue(op, pick_client(), pick_mask());
            if (op != apt_pkg::OP_UNUSED)
                sent++;
            if (sent == words / 2 || $urandom_range(99) == 0)
                drain();
            else if ($urandom_range(99) < idle_pct)
                pause(($urandom_range(3) == 0) ? $urandom_range(5, 22)
                                               : $urandom_range(1, 4));
        end
    endtask

    initial
    begin
        logic [apt_pkg::ID_BITS-1:0] cand;
        logic [apt_pkg::ID_BITS-1:0] phase_owner [4];
        int                          phase_idle  [4];
        bit                          clash;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nonzero owner so client zero stays the shared entry
        write_owner(apt_pkg::ID_BITS'($urandom) | apt_pkg::ID_BITS'(1));

        // distinct member ids away from zero, all ones and the owner
        for (int i = 0; i < apt_pkg::MAX_MEMBERS; i++)
        begin
            do
            begin
                cand  = apt_pkg::ID_BITS'($urandom);
                clash = (cand == '0) || (cand == '1) || (cand == owner_now);
                for (int j = 0; j < i; j++)
                    if (member_pool[j] == cand)
                        clash = 1'b1;
            end
            while (clash);
            member_pool[i] = cand;
        end

        // owner: grant succeeds, revoke refused, check always granted
        issue(apt_pkg::OP_GRANT,  owner_now, '1);
        issue(apt_pkg::OP_REVOKE, owner_now, '1);
        issue(apt_pkg::OP_CHECK,  owner_now, '0);
        // shared mask for client zero
        issue(apt_pkg::OP_CHECK,  '0, '1);
        issue(apt_pkg::OP_GRANT,  '0, '1);
        issue(apt_pkg::OP_CHECK,  '0, 16'h8000);
        issue(apt_pkg::OP_REVOKE, '0, 16'h7FFF);
        issue(apt_pkg::OP_CHECK,  '0, 16'h0001);
        // stranger: revoke succeeds without an entry, check then fails
        issue(apt_pkg::OP_REVOKE, '1, '1);
        issue(apt_pkg::OP_CHECK,  '1, '1);
        // unused operation is ignored
        issue(apt_pkg::OP_UNUSED, '0, '1);
        // fill the member table
        for (int i = 0; i < apt_pkg::MAX_MEMBERS; i++)
            issue(apt_pkg::OP_GRANT, member_pool[i],
                  (i == 0) ? '1 : apt_pkg::PERM_BITS'($urandom));
        issue(apt_pkg::OP_CHECK,  member_pool[0], 16'h0001);
        issue(apt_pkg::OP_REVOKE, member_pool[0], '1);
        issue(apt_pkg::OP_CHECK,  member_pool[0], '1);
        // grant to a new client into a full table
        issue(apt_pkg::OP_GRANT,  '1, '1);

        phase_owner[0] = '0;
        phase_owner[1] = '1;
        phase_owner[2] = member_pool[5];
        phase_owner[3] = apt_pkg::ID_BITS'($urandom);
        phase_idle[0]  = 0;
        phase_idle[1]  = 67;
        phase_idle[2]  = 0;
        phase_idle[3]  = 20;
        for (int p = 0; p < 4; p++)
        begin
            write_owner(phase_owner[p]);
            run_phase(PHASE_WORDS, phase_idle[p]);
        end

        drain();
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d request words under five owner settings and three idle mixes",
                 words_taken);
        $display("%0d grants were turned away by a full member table", full_rejects);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            if (outstanding != 0)
                $error("%0d expected results never arrived", outstanding);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
